// File: rtl/core/neighbor_liveness_table_top_assert.svh
// ---------------------------------------------------------------------------
// neighbor_liveness_table_top_assert.svh
// Assertion macros for the neighbor liveness table.
// ---------------------------------------------------------------------------
`ifndef NEIGHBOR_LIVENESS_TABLE_TOP_ASSERT_SVH
`define NEIGHBOR_LIVENESS_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NLT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nlt check failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define NLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nlt check failed: next-cycle rule");

`endif

// File: rtl/core/nlt_pkg.sv
// ---------------------------------------------------------------------------
// nlt_pkg
// Shared types and constants of the neighbor liveness table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlt_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int MISS_W = 4;
  localparam int INTV_W = 8;

  localparam logic [MISS_W-1:0] MISS_MAX        = 4'd15;
  localparam logic [INTV_W-1:0] INTERVAL_RESET  = 8'd5;
  localparam logic [MISS_W-1:0] MISS_LIMIT_RESET = 4'd3;

  localparam logic CFG_KEEPALIVE_SECS = 1'b0;
  localparam logic CFG_MISS_LIMIT     = 1'b1;

  localparam logic FUNC_HELLO = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_KNOWN = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2,
    ST_TICK  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

// File: rtl/core/neighbor_liveness_table_top.sv
// ---------------------------------------------------------------------------
// neighbor_liveness_table_top
// Hello/keepalive neighbor table: MAC lookup and add on hello, aging scan
// on each one-second tick.
//
//   channel  signals                              transfer when
//   in       in_valid in_ready func mac           in_valid && in_ready
//   out      out_valid out_ready status index     out_valid && out_ready
//            reconnected dropped_mask neighbor_count
//   cfg      cfg_we cfg_index cfg_data            cfg_we
//
// The scan walks up to the hit slot for a known hello and all used entries
// otherwise; an empty table still passes through the scan state. out_valid
// rises once the result state hands the result on; no new input is taken
// until the result has gone to the output register. One entry per cycle
// through the compare/age unit. Reset clears the seconds counter, the entry
// count, out_valid and the hit flag and loads the timer registers with their
// defaults; no clearing pass. An untaken result holds the next item in S_RESULT.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module neighbor_liveness_table_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [nlt_pkg::MAC_W-1:0]   mac,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [nlt_pkg::IDX_W-1:0]   index,
  output logic                        reconnected,
  output logic [nlt_pkg::DEPTH-1:0]   dropped_mask,
  output logic [nlt_pkg::CNT_W-1:0]   neighbor_count,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [nlt_pkg::INTV_W-1:0]  cfg_data
);
  import nlt_pkg::*;

  `include "neighbor_liveness_table_top_assert.svh"

  cmd_t cmd;
  sts_t sts;

  nlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nlt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .func           (func),
    .mac            (mac),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .index          (index),
    .reconnected    (reconnected),
    .dropped_mask   (dropped_mask),
    .neighbor_count (neighbor_count)
  );

  `NLT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `NLT_ASSERT_SAME(a_count_bound, out_valid, neighbor_count <= CNT_W'(DEPTH))
  `NLT_ASSERT_SAME(a_full_means_full, out_valid && (status == ST_FULL),
                   (neighbor_count == CNT_W'(DEPTH)) && (index == '0))
  `NLT_ASSERT_SAME(a_hello_no_drop, out_valid && (status != ST_TICK),
                   dropped_mask == '0)

endmodule

// File: rtl/core/nlt_ctrl.sv
// ---------------------------------------------------------------------------
// nlt_ctrl
// Controller: accept an item, walk the table, hand the result to the
// output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  nlt_pkg::sts_t sts,
  output nlt_pkg::cmd_t cmd
);
  import nlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/nlt_datapath.sv
// ---------------------------------------------------------------------------
// nlt_datapath
// Neighbor table storage, seconds counter, per-entry scan logic,
// configuration registers and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  nlt_pkg::cmd_t               cmd,
  output nlt_pkg::sts_t               sts,
  input  logic                        func,
  input  logic [nlt_pkg::MAC_W-1:0]   mac,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [nlt_pkg::INTV_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [nlt_pkg::IDX_W-1:0]   index,
  output logic                        reconnected,
  output logic [nlt_pkg::DEPTH-1:0]   dropped_mask,
  output logic [nlt_pkg::CNT_W-1:0]   neighbor_count
);
  import nlt_pkg::*;

  logic [MAC_W-1:0]  entry_mac       [DEPTH];
  logic [TIME_W-1:0] entry_last_seen [DEPTH];
  logic [MISS_W-1:0] entry_misses    [DEPTH];
  logic              entry_up        [DEPTH];

  logic [TIME_W-1:0] seconds_now;
  logic [CNT_W-1:0]  used;
  logic [INTV_W-1:0] keepalive_secs;
  logic [MISS_W-1:0] miss_limit;

  logic              func_q;
  logic [MAC_W-1:0]  mac_q;
  logic [IDX_W-1:0]  idx;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              recon;
  logic [DEPTH-1:0]  dropped;

  logic              empty;
  logic              last;
  logic              match;
  logic [TIME_W-1:0] age;
  logic              late;
  logic [MISS_W-1:0] miss_inc;
  logic              drop;
  logic              room;
  logic              do_step;
  logic              do_add;

  assign empty    = (used == '0);
  assign last     = ({1'b0, idx} == used - CNT_W'(1));
  assign match    = (entry_mac[idx] == mac_q);
  assign age      = seconds_now - entry_last_seen[idx];
  assign late     = entry_up[idx] && (age > TIME_W'(keepalive_secs));
  assign miss_inc = (entry_misses[idx] < MISS_MAX) ? entry_misses[idx] + MISS_W'(1)
                                                  : entry_misses[idx];
  assign drop     = late && (miss_inc >= miss_limit);
  assign room     = (used < CNT_W'(DEPTH));
  assign do_step  = cmd.step && !empty;
  assign do_add   = cmd.emit && (func_q == FUNC_HELLO) && !hit && room;

  assign sts.scan_done = empty || last || ((func_q == FUNC_HELLO) && match);
  assign sts.out_busy  = out_valid && !out_ready;

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_now    <= '0;
      used           <= '0;
      out_valid      <= 1'b0;
      hit            <= 1'b0;
      keepalive_secs <= INTERVAL_RESET;
      miss_limit     <= MISS_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEEPALIVE_SECS: keepalive_secs <= cfg_data;
          CFG_MISS_LIMIT:     miss_limit     <= cfg_data[MISS_W-1:0];
          default:            ;
        endcase
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        hit <= 1'b0;
        if (func == FUNC_TICK) begin
          seconds_now <= seconds_now + TIME_W'(1);
        end
      end
      if (do_step && (func_q == FUNC_HELLO) && match) begin
        hit <= 1'b1;
      end
      if (do_add) begin
        used <= used + CNT_W'(1);
      end
    end
  end

  // table entries, item payload and output fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      mac_q   <= mac;
      idx     <= '0;
      recon   <= 1'b0;
      dropped <= '0;
    end
    if (do_step) begin
      idx <= idx + IDX_W'(1);
      if (func_q == FUNC_TICK) begin
        if (late) begin
          entry_misses[idx] <= miss_inc;
          if (drop) begin
            entry_up[idx] <= 1'b0;
            dropped[idx]  <= 1'b1;
          end
        end
      end else if (match) begin
        entry_last_seen[idx] <= seconds_now;
        entry_misses[idx]    <= '0;
        entry_up[idx]        <= 1'b1;
        hit_idx              <= idx;
        recon                <= !entry_up[idx];
      end
    end
    if (do_add) begin
      entry_mac[used[IDX_W-1:0]]       <= mac_q;
      entry_last_seen[used[IDX_W-1:0]] <= seconds_now;
      entry_misses[used[IDX_W-1:0]]    <= '0;
      entry_up[used[IDX_W-1:0]]        <= 1'b1;
    end
    if (cmd.emit) begin
      if (func_q == FUNC_TICK) begin
        status         <= ST_TICK;
        index          <= '0;
        reconnected    <= 1'b0;
        dropped_mask   <= dropped;
        neighbor_count <= used;
      end else if (hit) begin
        status         <= ST_KNOWN;
        index          <= hit_idx;
        reconnected    <= recon;
        dropped_mask   <= '0;
        neighbor_count <= used;
      end else if (room) begin
        status         <= ST_ADDED;
        index          <= used[IDX_W-1:0];
        reconnected    <= 1'b0;
        dropped_mask   <= '0;
        neighbor_count <= used + CNT_W'(1);
      end else begin
        status         <= ST_FULL;
        index          <= '0;
        reconnected    <= 1'b0;
        dropped_mask   <= '0;
        neighbor_count <= used;
      end
    end
  end

endmodule

// File: tb/sv/neighbor_liveness_table_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// neighbor_liveness_table_checker
// Scoreboard for the neighbor liveness table. Mirrors the table, the seconds
// counter and both timer registers from the transfers it sees, queues one
// predicted reply per accepted item and compares every reply transfer with
// the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module neighbor_liveness_table_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        func,
  input  logic [nlt_pkg::MAC_W-1:0]   mac,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [1:0]                  status,
  input  logic [nlt_pkg::IDX_W-1:0]   index,
  input  logic                        reconnected,
  input  logic [nlt_pkg::DEPTH-1:0]   dropped_mask,
  input  logic [nlt_pkg::CNT_W-1:0]   neighbor_count,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [nlt_pkg::INTV_W-1:0]  cfg_data,
  output int                          errors,
  output int                          pending
);
  import nlt_pkg::*;

  typedef struct packed {
    logic [1:0]       st;
    logic [IDX_W-1:0] slot;
    logic             rejoined;
    logic [DEPTH-1:0] drops;
    logic [CNT_W-1:0] used;
  } reply_t;

  reply_t              awaited_replies[$];
  reply_t              want;
  logic [TIME_W-1:0]   clock_s;
  int unsigned         n_used;
  logic [MAC_W-1:0]    nb_mac[DEPTH];
  logic [TIME_W-1:0]   nb_seen[DEPTH];
  logic [MISS_W-1:0]   nb_miss[DEPTH];
  logic                nb_up[DEPTH];
  logic [INTV_W-1:0]   interval_s;
  logic [MISS_W-1:0]   miss_lim;

  function automatic reply_t age_table();
    reply_t            r;
    logic [TIME_W-1:0] age;
    r = '0;
    r.st = ST_TICK;
    clock_s = clock_s + TIME_W'(1);
    for (int i = 0; i < n_used; i++) begin
      if (nb_up[i]) begin
        age = clock_s - nb_seen[i];
        if (age > TIME_W'(interval_s)) begin
          if (nb_miss[i] < MISS_MAX) nb_miss[i] = nb_miss[i] + MISS_W'(1);
          if (nb_miss[i] >= miss_lim) begin
            nb_up[i] = 1'b0;
            r.drops[i] = 1'b1;
          end
        end
      end
    end
    r.used = CNT_W'(n_used);
    return r;
  endfunction

  function automatic reply_t learn_neighbor(input logic [MAC_W-1:0] m);
    reply_t r;
    int     hit;
    r = '0;
    hit = -1;
    for (int i = 0; i < n_used; i++) begin
      if (hit < 0 && nb_mac[i] == m) hit = i;
    end
    if (hit >= 0) begin
      r.st = ST_KNOWN;
      r.slot = IDX_W'(hit);
      r.rejoined = !nb_up[hit];
      nb_seen[hit] = clock_s;
      nb_miss[hit] = '0;
      nb_up[hit] = 1'b1;
    end else if (n_used < DEPTH) begin
      r.st = ST_ADDED;
      r.slot = IDX_W'(n_used);
      nb_mac[n_used] = m;
      nb_seen[n_used] = clock_s;
      nb_miss[n_used] = '0;
      nb_up[n_used] = 1'b1;
      n_used++;
    end else begin
      r.st = ST_FULL;
    end
    r.used = CNT_W'(n_used);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clock_s = '0;
      n_used = 0;
      interval_s = INTERVAL_RESET;
      miss_lim = MISS_LIMIT_RESET;
      for (int i = 0; i < DEPTH; i++) begin
        nb_mac[i] = '0;
        nb_seen[i] = '0;
        nb_miss[i] = '0;
        nb_up[i] = 1'b0;
      end
      awaited_replies.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KEEPALIVE_SECS) interval_s = cfg_data;
        else miss_lim = cfg_data[MISS_W-1:0];
      end
      if (in_valid && in_ready) begin
        if (func == FUNC_TICK) awaited_replies.push_back(age_table());
        else awaited_replies.push_back(learn_neighbor(mac));
      end
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          errors++;
          $error("reply transfer with no reply awaited");
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", 32'(want.st), 32'(status));
          check_field("index", 32'(want.slot), 32'(index));
          check_field("reconnected", 32'(want.rejoined), 32'(reconnected));
          check_field("dropped_mask", 32'(want.drops), 32'(dropped_mask));
          check_field("neighbor_count", 32'(want.used), 32'(neighbor_count));
        end
      end
      pending = awaited_replies.size();
    end
  end

endmodule

// File: tb/sv/neighbor_liveness_table_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// neighbor_liveness_table_top_tb
// Drives hellos and ticks into the neighbor liveness table under several
// timer settings: a directed opening (add, hit, full aging to disconnect,
// reconnect, zero interval and zero limit), then random traffic over a pool
// of neighbors with stray MACs, random idling on both sides and one long
// receiver hold-off. The checker instance predicts and compares.
// ---------------------------------------------------------------------------
module neighbor_liveness_table_top_tb;
  import nlt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int SQUEEZE_AT  = 400;
  localparam int DRAIN_WAIT  = 24;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                func;
  logic [MAC_W-1:0]    mac;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          status;
  logic [IDX_W-1:0]    index;
  logic                reconnected;
  logic [DEPTH-1:0]    dropped_mask;
  logic [CNT_W-1:0]    neighbor_count;
  logic                cfg_we;
  logic                cfg_index;
  logic [INTV_W-1:0]   cfg_data;
  int                  errors;
  int                  pending;

  logic [MAC_W-1:0]    nb_pool[DEPTH];
  int                  sent = 0;
  logic                calm = 1'b0;
  logic                squeeze = 1'b0;
  logic                squeezed = 1'b0;
  int unsigned         cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  neighbor_liveness_table_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .mac            (mac),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .index          (index),
    .reconnected    (reconnected),
    .dropped_mask   (dropped_mask),
    .neighbor_count (neighbor_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  neighbor_liveness_table_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .mac            (mac),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .index          (index),
    .reconnected    (reconnected),
    .dropped_mask   (dropped_mask),
    .neighbor_count (neighbor_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off to back up the input
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  task automatic send_item(input logic f, input logic [MAC_W-1:0] m);
    calm = (sent >= 700 && sent < 900);
    if (sent == SQUEEZE_AT) squeeze = 1'b1;
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    mac <= m;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic set_timers(input logic [INTV_W-1:0] intv_d, input logic [INTV_W-1:0] lim_d);
    cfg_we <= 1'b1;
    cfg_index <= CFG_KEEPALIVE_SECS;
    cfg_data <= intv_d;
    @(negedge clk);
    cfg_index <= CFG_MISS_LIMIT;
    cfg_data <= lim_d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic run_phase(input int items, input int tick_pct);
    logic [MAC_W-1:0] m;
    for (int k = 0; k < items; k++) begin
      m = MAC_W'({$urandom, $urandom});
      if ($urandom_range(99) < tick_pct) begin
        send_item(FUNC_TICK, m);
      end else begin
        if ($urandom_range(99) >= 6) m = nb_pool[IDX_W'($urandom_range(DEPTH - 1))];
        send_item(FUNC_HELLO, m);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_HELLO;
    mac = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_KEEPALIVE_SECS;
    cfg_data = '0;
    nb_pool[0] = '0;
    nb_pool[1] = '1;
    nb_pool[2] = {24{2'b01}};
    nb_pool[3] = {24{2'b10}};
    for (int i = 4; i < DEPTH; i++) nb_pool[i] = MAC_W'({$urandom, $urandom});
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(FUNC_TICK, '1);
    send_item(FUNC_HELLO, nb_pool[0]);
    send_item(FUNC_HELLO, nb_pool[1]);
    send_item(FUNC_HELLO, nb_pool[0]);
    send_item(FUNC_HELLO, nb_pool[2]);
    send_item(FUNC_HELLO, nb_pool[3]);
    // age every entry past the interval until the limit drops it
    repeat (9) send_item(FUNC_TICK, '0);
    send_item(FUNC_HELLO, nb_pool[0]);
    repeat (2) send_item(FUNC_TICK, '0);
    drain();

    // zero interval, zero limit with upper data bits set
    set_timers(8'd0, 8'hF0);
    send_item(FUNC_HELLO, nb_pool[1]);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_HELLO, nb_pool[2]);
    drain();

    set_timers(8'd255, 8'h0F);
    run_phase(256, 40);
    drain();
    set_timers(8'd1, 8'h01);
    run_phase(256, 40);
    drain();
    set_timers(8'd2, 8'hFF);
    run_phase(256, 70);
    drain();
    set_timers(8'd3, 8'h02);
    run_phase(256, 45);
    drain();
    set_timers(INTV_W'($urandom_range(0, 6)), INTV_W'($urandom));
    run_phase(256, 50);
    drain();

    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
